>>> hdl/sscpg_pkg.sv
// ----------------------------------------------------------------------------
// sscpg_pkg: shared types and constants of the stepper S-curve profile unit
// Item layouts on the stream ports, command codes, phase codes and the
// one-hot profile state encoding.
// ----------------------------------------------------------------------------
package sscpg_pkg;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned InDataW  = 80;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 88;

  // Half-period after reset, in timer ticks
  localparam logic [15:0] HalfReset = 16'd2000;

  // Command codes carried in the input tuser
  typedef enum logic [1:0] {
    CMD_START_X = 2'd0,
    CMD_START_Y = 2'd1,
    CMD_EVENT   = 2'd2,
    CMD_LOAD    = 2'd3
  } cmd_e;

  // Phase codes as they appear in the result item
  localparam logic [1:0] PHASE_CODE_STOP   = 2'd0;
  localparam logic [1:0] PHASE_CODE_ACCEL  = 2'd1;
  localparam logic [1:0] PHASE_CODE_CRUISE = 2'd2;
  localparam logic [1:0] PHASE_CODE_DECEL  = 2'd3;

  // Profile state, one-hot
  typedef enum logic [3:0] {
    PH_STOP   = 4'b0001,
    PH_ACCEL  = 4'b0010,
    PH_CRUISE = 4'b0100,
    PH_DECEL  = 4'b1000
  } phase_e;

  // Input item, last declared field in the lowest bits
  typedef struct packed {
    logic [2:0]         pad;
    logic signed [1:0]  y_motion;
    logic signed [1:0]  x_motion;
    logic [15:0]        capture_count;
    logic [15:0]        table_period;
    logic [7:0]         table_index;
    logic [31:0]        pulse_total;
    logic               direction_up;
  } in_data_t;

  // Result item, last declared field in the lowest bits
  typedef struct packed {
    logic [2:0]         pad;
    logic signed [31:0] y_steps;
    logic signed [31:0] x_steps;
    logic [1:0]         phase;
    logic               running;
    logic               dir_pin_c;
    logic               dir_pin_a;
    logic [15:0]        next_compare;
  } out_data_t;

  function automatic logic [1:0] phase_code(phase_e ph);
    logic [1:0] code;
    case (ph)
      PH_ACCEL:  code = PHASE_CODE_ACCEL;
      PH_CRUISE: code = PHASE_CODE_CRUISE;
      PH_DECEL:  code = PHASE_CODE_DECEL;
      default:   code = PHASE_CODE_STOP;
    endcase
    return code;
  endfunction

endpackage

>>> hdl/stepper_s_curve_profile_generator_unit.sv
// ----------------------------------------------------------------------------
// stepper_s_curve_profile_generator_unit: stepper pulse profile generator
// Runs an accelerate / cruise / decelerate profile over a loaded table of
// toggle periods, driven by timer compare events, and tracks X/Y step totals.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Sideband         Payload
//  --------  ---------  ---------------  -------------------------------------
//  s_axis    in         tuser = command  direction, total, table entry,
//                                        capture count, X/Y motion signs
//  m_axis    out        none             next compare, pins, running, phase,
//                                        X/Y step totals
//
//  Flow:    one item per cycle while m_axis is not stalled; an accepted item
//           fills the input register and then loads the result register, from
//           which it shows on m_axis.
//  Table:   a memory of TABLE_LEN entries with one write port and one
//           registered read port; the read address is taken from the next
//           profile state, so the entry needed by the following compare event
//           is ready in time. A load to the entry being read is forwarded into
//           the read register.
//  Reset:   control state clears at once; the table is not cleared and must be
//           loaded before a move is started.
//  Stalls:  the result register holds a valid item while m_axis_tready is low;
//           the input register takes an item when empty or when its item moves on.
//
module stepper_s_curve_profile_generator_unit #(
  parameter int unsigned TABLE_LEN = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // slave side
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata, from bit 0 up: direction_up, pulse_total, table_index,
  //   table_period, capture_count, x_motion, y_motion, zero pad
  input  logic [sscpg_pkg::InDataW-1:0] s_axis_tdata,
  // tuser: command
  input  logic [sscpg_pkg::InUserW-1:0] s_axis_tuser,
  // master side
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata, from bit 0 up: next_compare, dir_pin_a, dir_pin_c, running,
  //   phase, x_steps, y_steps, zero pad
  output logic [sscpg_pkg::OutDataW-1:0] m_axis_tdata
);

  import sscpg_pkg::*;

  localparam int unsigned IdxW     = (TABLE_LEN > 1) ? $clog2(TABLE_LEN) : 1;
  localparam logic [31:0] Len      = 32'(TABLE_LEN);
  localparam logic [31:0] Overhead = 32'(2 * TABLE_LEN + 1);
  localparam logic [7:0]  LenIdx   = 8'(TABLE_LEN);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_LEN - 1);

  // Input register
  logic     in_valid_q;
  in_data_t in_data_q;
  cmd_e     in_cmd_q;
  logic     fire;

  // Result register
  logic      out_valid_q;
  out_data_t out_data_q, out_data_d;

  // Profile state
  phase_e      phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] cruise_q, cruise_d;
  logic [15:0] half_q, half_d;
  logic        parity_q, parity_d;
  logic [31:0] x_q, x_d;
  logic [31:0] y_q, y_d;
  logic        pin_a_q, pin_a_d;
  logic        pin_c_q, pin_c_d;
  logic        run_q, run_d;

  logic [31:0] pos_inc;
  logic [15:0] compare;

  // Speed table
  logic [15:0]     table_mem [TABLE_LEN];
  logic [15:0]     rd_data_q;
  logic [15:0]     tbl_half;
  logic [IdxW-1:0] rd_addr;
  logic [IdxW-1:0] wr_addr;
  logic            wr_en;

  function automatic logic [31:0] motion_apply(logic [31:0] total,
                                               logic signed [1:0] m);
    logic [31:0] res;
    if (m == 2'sd1) begin
      res = total + 32'd1;
    end else if (m[1]) begin
      res = total - 32'd1;
    end else begin
      res = total;
    end
    return res;
  endfunction

  // Advance the input stage whenever the result register is free or drains
  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= in_data_t'(s_axis_tdata);
      in_cmd_q  <= cmd_e'(s_axis_tuser);
    end
  end

  assign tbl_half = {1'b0, rd_data_q[15:1]};
  assign pos_inc  = pos_q + 32'd1;

  // Next-state logic for the item in the input register
  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    cruise_d = cruise_q;
    half_d   = half_q;
    parity_d = parity_q;
    x_d      = x_q;
    y_d      = y_q;
    pin_a_d  = pin_a_q;
    pin_c_d  = pin_c_q;
    run_d    = run_q;
    compare  = 16'd0;
    wr_en    = 1'b0;
    if (fire) begin
      case (in_cmd_q)
        CMD_START_X, CMD_START_Y: begin
          pos_d    = 32'd0;
          phase_d  = PH_ACCEL;
          cruise_d = (in_data_q.pulse_total > Overhead) ?
                     in_data_q.pulse_total - Overhead : 32'd0;
          pin_c_d  = in_data_q.direction_up;
          pin_a_d  = (in_cmd_q == CMD_START_X) ? in_data_q.direction_up
                                               : !in_data_q.direction_up;
          run_d    = 1'b1;
        end
        CMD_EVENT: begin
          x_d      = motion_apply(x_q, in_data_q.x_motion);
          y_d      = motion_apply(y_q, in_data_q.y_motion);
          parity_d = !parity_q;
          // advance the profile on every second event
          if (parity_q) begin
            case (phase_q)
              PH_ACCEL: begin
                half_d = tbl_half;
                if (pos_inc >= Len) begin
                  phase_d = (cruise_q != 32'd0) ? PH_CRUISE : PH_DECEL;
                  pos_d   = 32'd0;
                end else begin
                  pos_d = pos_inc;
                end
              end
              PH_CRUISE: begin
                half_d = tbl_half;
                if (pos_inc == cruise_q) begin
                  phase_d = PH_DECEL;
                  pos_d   = 32'd0;
                end else begin
                  pos_d = pos_inc;
                end
              end
              PH_DECEL: begin
                if (pos_q < Len) begin
                  half_d = tbl_half;
                  pos_d  = pos_inc;
                end else begin
                  run_d   = 1'b0;
                  pos_d   = 32'd0;
                  phase_d = PH_STOP;
                end
              end
              default: begin
              end
            endcase
          end
          compare = in_data_q.capture_count + half_d;
        end
        CMD_LOAD: begin
          wr_en = (in_data_q.table_index < LenIdx);
        end
        default: begin
        end
      endcase
    end
  end

  // Table address needed by the next advance, taken from the next state
  always_comb begin
    case (phase_d)
      PH_ACCEL:  rd_addr = pos_d[IdxW-1:0];
      PH_CRUISE: rd_addr = LastIdx;
      PH_DECEL:  rd_addr = LastIdx - pos_d[IdxW-1:0];
      default:   rd_addr = '0;
    endcase
  end

  assign wr_addr = in_data_q.table_index[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[wr_addr] <= in_data_q.table_period;
    end
  end

  // Forward a load that hits the entry being read
  always_ff @(posedge clk_i) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_q <= in_data_q.table_period;
    end else begin
      rd_data_q <= table_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_STOP;
      pos_q    <= 32'd0;
      cruise_q <= 32'd0;
      half_q   <= HalfReset;
      parity_q <= 1'b0;
      x_q      <= 32'd0;
      y_q      <= 32'd0;
      pin_a_q  <= 1'b0;
      pin_c_q  <= 1'b0;
      run_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      cruise_q <= cruise_d;
      half_q   <= half_d;
      parity_q <= parity_d;
      x_q      <= x_d;
      y_q      <= y_d;
      pin_a_q  <= pin_a_d;
      pin_c_q  <= pin_c_d;
      run_q    <= run_d;
    end
  end

  // Result item shows the state after the command
  always_comb begin
    out_data_d              = '0;
    out_data_d.next_compare = compare;
    out_data_d.dir_pin_a    = pin_a_d;
    out_data_d.dir_pin_c    = pin_c_d;
    out_data_d.running      = run_d;
    out_data_d.phase        = phase_code(phase_d);
    out_data_d.x_steps      = x_d;
    out_data_d.y_steps      = y_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> hdl/sscpg_checker.sv
// ----------------------------------------------------------------------------
// sscpg_checker: port-level checks for the stepper S-curve profile unit
// Watches both stream channels and flags timing and result slips.
// ----------------------------------------------------------------------------
module sscpg_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [sscpg_pkg::InDataW-1:0]  s_axis_tdata,
  input logic [sscpg_pkg::InUserW-1:0]  s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [sscpg_pkg::OutDataW-1:0] m_axis_tdata
);

  import sscpg_pkg::*;

  out_data_t   res;
  logic        s_acc;
  logic        m_acc;
  logic [31:0] last_x_q;
  logic [31:0] x_delta;

  assign res     = out_data_t'(m_axis_tdata);
  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign m_acc   = m_axis_tvalid && m_axis_tready;
  assign x_delta = res.x_steps - last_x_q;

  // hold the X total of the last delivered item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_x_q <= 32'd0;
    end else if (m_acc) begin
      last_x_q <= res.x_steps;
    end
  end

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  // a result into an empty output follows an accepted input item
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_acc, 2))
    else $error("result item without an accepted input item");

  // the timer runs exactly while a phase other than stopped is shown
  a_run_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.running == (res.phase != PHASE_CODE_STOP)))
    else $error("running flag disagrees with phase");

  // the X total moves by at most one step per item
  a_x_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_acc |-> (x_delta == 32'd0 || x_delta == 32'd1 || x_delta == 32'hFFFF_FFFF))
    else $error("X step total jumped");

endmodule

bind stepper_s_curve_profile_generator_unit sscpg_checker u_sscpg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> tb/tb_stepper_s_curve_profile_generator_unit.sv
// ----------------------------------------------------------------------------
// tb_stepper_s_curve_profile_generator_unit: self-checking bench of the unit
// Loads the speed table, walks a short table of directed items, then runs
// random moves (start, a full or cut-short train of compare events, stray
// loads). Every result item is checked against a local profile predictor or a fixed result.
// ----------------------------------------------------------------------------
module tb_stepper_s_curve_profile_generator_unit;
  import sscpg_pkg::*;

  localparam int          ClkPeriod   = 8;
  localparam int          TableLen    = 64;
  localparam logic [31:0] Overhead    = 2 * TableLen + 1;
  localparam int          RandomItems = 1700;
  localparam int          LimitCycles = 300_000;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [InUserW-1:0]  s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  stepper_s_curve_profile_generator_unit #(
    .TABLE_LEN(TableLen)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // One row of the directed table; a fixed result overrides the predictor
  typedef struct {
    cmd_e      cmd;
    in_data_t  item;
    bit        has_fixed;
    out_data_t fixed;
  } plan_row_t;

  // Predicted profile state, reset values
  logic [15:0] speed_tbl [TableLen];
  logic [31:0] ramp_pos   = '0;
  logic [31:0] cruise_len = '0;
  logic [31:0] x_tot      = '0;
  logic [31:0] y_tot      = '0;
  logic [15:0] half_ticks = HalfReset;
  logic [1:0]  phase_q    = PHASE_CODE_STOP;
  logic        parity     = 1'b0;
  logic        pin_a      = 1'b0;
  logic        pin_c      = 1'b0;
  logic        run        = 1'b0;

  out_data_t pending_outputs [$];
  int        mismatch_count = 0;
  int        items_sent     = 0;
  int        burst_left     = 0;
  int        stall_span     = 0;
  int        stall_pct      = 0;

  function automatic in_data_t pack_item(logic up, logic [31:0] total, logic [7:0] idx,
                                         logic [15:0] period, logic [15:0] cap,
                                         logic [1:0] xm, logic [1:0] ym);
    in_data_t d;
    d = '0;
    d.direction_up  = up;
    d.pulse_total   = total;
    d.table_index   = idx;
    d.table_period  = period;
    d.capture_count = cap;
    d.x_motion      = xm;
    d.y_motion      = ym;
    return d;
  endfunction

  function automatic out_data_t pack_result(logic [15:0] cmp, logic a, logic c, logic en,
                                            logic [1:0] ph, logic [31:0] xs,
                                            logic [31:0] ys);
    out_data_t r;
    r = '0;
    r.next_compare = cmp;
    r.dir_pin_a    = a;
    r.dir_pin_c    = c;
    r.running      = en;
    r.phase        = ph;
    r.x_steps      = xs;
    r.y_steps      = ys;
    return r;
  endfunction

  // Fill every field with random bits, motion codes included
  function automatic in_data_t rand_item();
    return pack_item(1'($urandom_range(0, 1)), 32'($urandom),
                     8'($urandom_range(0, 255)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
  endfunction

  // Positive code counts up, any code with the sign bit set counts down
  function automatic logic [31:0] step_total(logic [31:0] total, logic [1:0] motion);
    if (motion == 2'b01) return total + 32'd1;
    if (motion[1]) return total - 32'd1;
    return total;
  endfunction

  // Apply one item to the predicted state and return its result item
  function automatic out_data_t predict_profile(cmd_e cmd, in_data_t d);
    logic [15:0] cmp;
    cmp = '0;
    case (cmd)
      CMD_START_X, CMD_START_Y: begin
        ramp_pos   = '0;
        phase_q    = PHASE_CODE_ACCEL;
        cruise_len = (d.pulse_total > Overhead) ? d.pulse_total - Overhead : '0;
        pin_c      = d.direction_up;
        pin_a      = (cmd == CMD_START_X) ? d.direction_up : ~d.direction_up;
        run        = 1'b1;
      end
      CMD_EVENT: begin
        x_tot  = step_total(x_tot, d.x_motion);
        y_tot  = step_total(y_tot, d.y_motion);
        parity = ~parity;
        // Advance the profile on every second event only
        if (!parity) begin
          case (phase_q)
            PHASE_CODE_ACCEL: begin
              ramp_pos   = ramp_pos + 1;
              half_ticks = speed_tbl[ramp_pos - 1] >> 1;
              if (ramp_pos >= TableLen) begin
                phase_q  = (cruise_len != 0) ? PHASE_CODE_CRUISE : PHASE_CODE_DECEL;
                ramp_pos = '0;
              end
            end
            PHASE_CODE_CRUISE: begin
              ramp_pos   = ramp_pos + 1;
              half_ticks = speed_tbl[TableLen - 1] >> 1;
              if (ramp_pos == cruise_len) begin
                phase_q  = PHASE_CODE_DECEL;
                ramp_pos = '0;
              end
            end
            PHASE_CODE_DECEL: begin
              ramp_pos = ramp_pos + 1;
              if (ramp_pos < TableLen + 1) begin
                half_ticks = speed_tbl[TableLen - ramp_pos] >> 1;
              end else begin
                // Past the last decelerate entry: stop the timer, keep the half-period
                run      = 1'b0;
                ramp_pos = '0;
                phase_q  = PHASE_CODE_STOP;
              end
            end
            default: ;
          endcase
        end
        cmp = d.capture_count + half_ticks;
      end
      default: begin
        if (d.table_index < TableLen) speed_tbl[d.table_index[5:0]] = d.table_period;
      end
    endcase
    return pack_result(cmp, pin_a, pin_c, run, phase_q, x_tot, y_tot);
  endfunction

  // Drive one item in bursts with random gaps; predict it once accepted
  task automatic send_item(input cmd_e cmd, input in_data_t d, input bit has_fixed = 1'b0,
                           input out_data_t fixed = '0);
    int gap;
    out_data_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = predict_profile(cmd, d);
    pending_outputs.push_back(has_fixed ? fixed : predicted);
    items_sent++;
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Receiver: stall at a random rate, chosen anew at the end of each random span
  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_span <= $urandom_range(100, 400);
      case ($urandom_range(0, 3))
        0:       stall_pct <= 0;
        1:       stall_pct <= 20;
        2:       stall_pct <= 50;
        default: stall_pct <= 80;
      endcase
    end else begin
      stall_span <= stall_span - 1;
    end
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Compare each accepted result item with the oldest prediction
  always @(posedge clk_i) begin : result_check
    out_data_t got;
    out_data_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_outputs.size() == 0) begin
        $error("result item with no item pending: %h", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_outputs.pop_front();
        check_field("next_compare", want.next_compare, got.next_compare);
        check_field("dir_pin_a", want.dir_pin_a, got.dir_pin_a);
        check_field("dir_pin_c", want.dir_pin_c, got.dir_pin_c);
        check_field("running", want.running, got.running);
        check_field("phase", want.phase, got.phase);
        check_field("x_steps", want.x_steps, got.x_steps);
        check_field("y_steps", want.y_steps, got.y_steps);
      end
    end
  end

  initial begin
    #(LimitCycles * ClkPeriod);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    plan_row_t   plan [$];
    in_data_t    d;
    cmd_e        cmd;
    logic [31:0] total;
    logic [31:0] cruise;
    int          n_events;
    int          first_random;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Write every table entry before any move can read one
    for (int i = 0; i < TableLen; i++) begin
      d = rand_item();
      d.table_index = 8'(i);
      send_item(CMD_LOAD, d);
    end

    // Events while stopped: totals move, half-period stays at its reset value
    plan.push_back('{CMD_EVENT, pack_item(0, 0, 0, 0, 16'h0000, 2'b00, 2'b00), 1'b1,
                     pack_result(16'd2000, 0, 0, 0, PHASE_CODE_STOP, 0, 0)});
    plan.push_back('{CMD_EVENT, pack_item(1, '1, '1, '1, 16'hFFFF, 2'b01, 2'b11), 1'b1,
                     pack_result(16'd1999, 0, 0, 0, PHASE_CODE_STOP, 1, '1)});
    plan.push_back('{CMD_EVENT, pack_item(0, 0, 0, 0, 16'h8000, 2'b11, 2'b01), 1'b1,
                     pack_result(16'h87D0, 0, 0, 0, PHASE_CODE_STOP, 0, 0)});
    plan.push_back('{CMD_EVENT, pack_item(0, 0, 0, 0, 16'h1234, 2'b10, 2'b10), 1'b1,
                     pack_result(16'h1A04, 0, 0, 0, PHASE_CODE_STOP, '1, '1)});
    // Loads at both ends of the table, then out of range (ignored)
    plan.push_back('{CMD_LOAD, pack_item(1, '1, 8'd0, 16'hFFFF, 0, 0, 0), 1'b1,
                     pack_result(0, 0, 0, 0, PHASE_CODE_STOP, '1, '1)});
    plan.push_back('{CMD_LOAD, pack_item(0, 0, 8'd63, 16'h0000, '1, 0, 0), 1'b1,
                     pack_result(0, 0, 0, 0, PHASE_CODE_STOP, '1, '1)});
    plan.push_back('{CMD_LOAD, pack_item(0, 0, 8'd64, 16'h1234, 0, 0, 0), 1'b1,
                     pack_result(0, 0, 0, 0, PHASE_CODE_STOP, '1, '1)});
    plan.push_back('{CMD_LOAD, pack_item(1, 0, 8'd255, 16'hFFFF, 0, 0, 0), 1'b1,
                     pack_result(0, 0, 0, 0, PHASE_CODE_STOP, '1, '1)});
    // Starts in both styles and directions; each one restarts the move
    plan.push_back('{CMD_START_X, pack_item(1, '1, 0, 0, 0, 0, 0), 1'b1,
                     pack_result(0, 1, 1, 1, PHASE_CODE_ACCEL, '1, '1)});
    plan.push_back('{CMD_START_X, pack_item(0, 0, 0, 0, 0, 0, 0), 1'b1,
                     pack_result(0, 0, 0, 1, PHASE_CODE_ACCEL, '1, '1)});
    plan.push_back('{CMD_START_Y, pack_item(1, Overhead, 0, 0, 0, 0, 0), 1'b1,
                     pack_result(0, 0, 1, 1, PHASE_CODE_ACCEL, '1, '1)});
    plan.push_back('{CMD_START_Y, pack_item(0, Overhead + 1, 0, 0, 0, 0, 0), 1'b1,
                     pack_result(0, 1, 0, 1, PHASE_CODE_ACCEL, '1, '1)});
    // First accelerate steps, capture at both extremes
    plan.push_back('{CMD_EVENT, pack_item(0, 0, 0, 0, 16'h0000, 2'b01, 2'b00), 1'b0, '0});
    plan.push_back('{CMD_EVENT, pack_item(0, 0, 0, 0, 16'hFFFF, 2'b01, 2'b11), 1'b0, '0});
    plan.push_back('{CMD_EVENT, pack_item(0, 0, 0, 0, 16'hFFFF, 2'b00, 2'b01), 1'b0, '0});
    plan.push_back('{CMD_EVENT, pack_item(0, 0, 0, 0, 16'h0000, 2'b11, 2'b10), 1'b0, '0});

    foreach (plan[i]) send_item(plan[i].cmd, plan[i].item, plan[i].has_fixed,
                                plan[i].fixed);

    // Random moves: mostly full trains, some cut short by the next start
    first_random = items_sent;
    while (items_sent - first_random < RandomItems) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: total = $urandom_range(0, Overhead);        // zero cruise
        4, 5, 6, 7: total = $urandom_range(Overhead + 1, 180);
        8:          total = Overhead + 1;                       // one cruise step
        default:    total = $urandom;
      endcase
      cmd = $urandom_range(0, 1) ? CMD_START_Y : CMD_START_X;
      d = rand_item();
      d.pulse_total = total;
      send_item(cmd, d);
      cruise = (total > Overhead) ? total - Overhead : '0;
      if (cruise > 200 || $urandom_range(0, 6) == 0)
        n_events = $urandom_range(0, 300);
      else
        n_events = 2 * (int'(Overhead) + int'(cruise)) + $urandom_range(0, 6);
      for (int k = 0; k < n_events && items_sent - first_random < RandomItems; k++) begin
        // Drop in a stray load now and then
        if ($urandom_range(0, 19) == 0) send_item(CMD_LOAD, rand_item());
        send_item(CMD_EVENT, rand_item());
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then let the pipeline run on so that stray items would show
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
